[rtl/bollinger_band_tracker_macros.svh]
// Assertion macros used by the band tracker RTL.
`ifndef BOLLINGER_BAND_TRACKER_MACROS_SVH
`define BOLLINGER_BAND_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bollinger_band_tracker: check failed");

// Next-cycle implication, checked outside reset.
`define BBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bollinger_band_tracker: check failed");

`endif

[rtl/bbt_pkg.sv]
// Shared constants, register codes and unit status type of the band tracker.
package bbt_pkg;

  localparam int WINDOW_MAX_DEF = 64;

  localparam int PRICE_W    = 32;
  localparam int WLEN_W     = 7;
  localparam int FACTOR_W   = 16;
  localparam int VAR_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int FRAC_SHIFT = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH_FACTOR = 2'd1;

  localparam logic [WLEN_W-1:0]   WLEN_RESET   = 7'd20;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd512;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

[rtl/bbt_div.sv]
// Shared radix-2 restoring divider: one quotient bit per cycle.
module bbt_div #(
  parameter int DW = bbt_pkg::VAR_W + $clog2(bbt_pkg::WINDOW_MAX_DEF),
  parameter int VW = $clog2(bbt_pkg::WINDOW_MAX_DEF + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [VW-1:0]      divisor,
  output logic [DW-1:0]      quotient,
  output bbt_pkg::unit_sts_t sts
);

  localparam int CW = $clog2(DW);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW-1:0] dvd_r;
  logic [VW-1:0] dvs_r;
  logic [VW-1:0] rem_r;

  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_diff;
  logic          fits;
  logic [VW-1:0] rem_nxt;
  logic [DW-1:0] dvd_nxt;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DW-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    fits     = (rem_sh >= {1'b0, dvs_r});
    rem_nxt  = fits ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
    dvd_nxt  = {dvd_r[DW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(DW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dvd_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[rtl/bbt_sqrt.sv]
// Digit-by-digit integer square root: one root bit per cycle.
module bbt_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bbt_pkg::VAR_W-1:0]    radicand,
  output logic [bbt_pkg::ROOT_W-1:0]   root,
  output bbt_pkg::unit_sts_t           sts
);

  localparam int RW = bbt_pkg::ROOT_W;
  localparam int VW = bbt_pkg::VAR_W;
  localparam int CW = $clog2(RW);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW-1:0] v_r;
  logic [RW-1:0] root_r;
  logic [RW+1:0] rem_r;

  logic [RW+3:0] rem_sh;
  logic [RW+3:0] trial;
  logic [RW+3:0] rem_diff;
  logic          fits;

  always_comb begin
    rem_sh   = {rem_r, v_r[VW-1:VW-2]};
    trial    = {2'b00, root_r, 2'b01};
    rem_diff = rem_sh - trial;
    fits     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(RW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(RW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[VW-3:0], 2'b00};
      root_r <= {root_r[RW-2:0], fits};
      rem_r  <= fits ? rem_diff[RW+1:0] : rem_sh[RW+1:0];
    end
  end

  assign root     = root_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[rtl/bollinger_band_tracker.sv]
// Top level of the Bollinger band tracker: ring, sequencer, passes and band math.
//
// Usage:
//   Input channel (in_valid / in_stall / in_price): one unsigned Q16.16 price per
//   item. in_stall is high while an item is being worked on; one item at a time.
//   Result channel (out_valid / out_stall / out_*): exactly one result per price.
//   Until window_length prices have arrived, bands_valid and all bands read 0.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; index 0 is window_length, 1 is band_width_factor (Q8.8).
//   Write config only while the block is idle.
// Sequence (L = effective window length):
//   window not full: straight from the check to the result; the next item is taken
//   after the result loads. Otherwise the two ring passes (one registered read port,
//   one entry per cycle), the two divides by L in the shared serial divider (one bit
//   per cycle) and the 32-step square root all come before the result.
// Reset: synchronous, active low. Clears fill count, write slot and the output
//   valid; restores window_length = 20, factor = 2.0. The ring needs no clearing.
// Stall: a finished result waits in the output register; the next price is
//   taken meanwhile, and its result waits in the final state until the slot frees.
`include "bollinger_band_tracker_macros.svh"

module bollinger_band_tracker #(
  parameter int WINDOW_MAX = bbt_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bbt_pkg::PRICE_W-1:0]       in_price,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_bands_valid,
  output logic [bbt_pkg::PRICE_W-1:0]       out_mean_price,
  output logic [bbt_pkg::PRICE_W-1:0]       out_upper_band,
  output logic [bbt_pkg::PRICE_W-1:0]       out_lower_band,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW     = bbt_pkg::PRICE_W;
  localparam int LOGW   = $clog2(WINDOW_MAX);
  localparam int AW     = LOGW;
  localparam int LW     = $clog2(WINDOW_MAX + 1);
  localparam int SW     = PW + LOGW;
  localparam int DW     = bbt_pkg::VAR_W + LOGW;
  localparam int FW     = bbt_pkg::FACTOR_W;
  localparam int RW     = bbt_pkg::ROOT_W;
  localparam int MW     = FW + RW;
  localparam int PRW    = MW - bbt_pkg::FRAC_SHIFT;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_DIV1  = 3'd3;
  localparam logic [2:0] ST_SQ    = 3'd4;
  localparam logic [2:0] ST_DIV2  = 3'd5;
  localparam logic [2:0] ST_ROOT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // control state
  logic [2:0]                 state_r;
  logic [AW-1:0]              wslot_r;
  logic [LW-1:0]              fill_r;
  logic [bbt_pkg::WLEN_W-1:0] wlen_r;
  logic [FW-1:0]              factor_r;
  logic                       out_valid_r;
  logic                       bands_ok_r;
  logic                       v1_r;
  logic                       v2_r;
  logic [LW-1:0]              iss_cnt_r;

  // datapath
  logic [PW-1:0]  ring_mem [WINDOW_MAX];
  logic [PW-1:0]  rd_data_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW-1:0]  newest_r;
  logic [SW-1:0]  sum_r;
  logic [DW-1:0]  acc_r;
  logic [63:0]    sq_r;
  logic [PW-1:0]  mean_r;
  logic [PRW-1:0] prod_r;
  logic [PW-1:0]  out_mean_r;
  logic [PW-1:0]  out_upper_r;
  logic [PW-1:0]  out_lower_r;
  logic           out_bv_r;

  // combinational
  logic               in_acc;
  logic               cfg_we;
  logic [31:0]        len_full;
  logic [LW-1:0]      len;
  logic               in_pass;
  logic               issuing;
  logic               pass_done;
  logic [PW-1:0]      dev;
  logic [63:0]        sq_nxt;
  logic [MW-1:0]      fprod;
  logic [PRW-1:0]     prod_nxt;
  logic [PRW:0]       up_sum;
  logic [PW-1:0]      upper_nxt;
  logic [PW-1:0]      lower_nxt;
  logic               out_load;
  logic               div_start;
  logic [DW-1:0]      div_dvd;
  logic [DW-1:0]      div_q;
  bbt_pkg::unit_sts_t div_sts;
  logic               sqrt_start;
  logic [RW-1:0]      sqrt_root;
  bbt_pkg::unit_sts_t sqrt_sts;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Clamp the configured length into 1..WINDOW_MAX.
  always_comb begin
    if (wlen_r == '0) begin
      len_full = 32'd1;
    end else if (32'(wlen_r) > 32'(WINDOW_MAX)) begin
      len_full = 32'(WINDOW_MAX);
    end else begin
      len_full = 32'(wlen_r);
    end
    len = len_full[LW-1:0];
  end

  // Pass control: issue one ring read per cycle, drain the read/multiply stages.
  assign in_pass   = (state_r == ST_SUM) || (state_r == ST_SQ);
  assign issuing   = in_pass && (iss_cnt_r != len);
  assign pass_done = in_pass && (iss_cnt_r == len) && !v1_r && !v2_r;

  always_comb begin
    dev    = (rd_data_r >= mean_r) ? (rd_data_r - mean_r) : (mean_r - rd_data_r);
    sq_nxt = 64'(dev) * 64'(dev);
  end

  always_comb begin
    fprod    = MW'(factor_r) * MW'(sqrt_root);
    prod_nxt = fprod[MW-1:bbt_pkg::FRAC_SHIFT];
  end

  // Band arithmetic: saturate high at all ones, low at zero.
  always_comb begin
    up_sum    = (PRW + 1)'(mean_r) + (PRW + 1)'(prod_r);
    upper_nxt = (|up_sum[PRW:PW]) ? '1 : up_sum[PW-1:0];
    lower_nxt = (prod_r >= PRW'(mean_r)) ? '0 : (mean_r - prod_r[PW-1:0]);
  end

  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign div_start  = pass_done;
  assign div_dvd    = (state_r == ST_SUM) ? DW'(sum_r) : acc_r;
  assign sqrt_start = (state_r == ST_DIV2) && div_sts.done;

  bbt_div #(
    .DW (DW),
    .VW (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (len),
    .quotient (div_q),
    .sts      (div_sts)
  );

  bbt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (div_q[bbt_pkg::VAR_W-1:0]),
    .root     (sqrt_root),
    .sts      (sqrt_sts)
  );

  // Ring: one write port at accept, one registered read port for the passes.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_mem[wslot_r] <= in_price;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= ring_mem[rd_ptr_r];
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wslot_r     <= '0;
      fill_r      <= '0;
      wlen_r      <= bbt_pkg::WLEN_RESET;
      factor_r    <= bbt_pkg::FACTOR_RESET;
      out_valid_r <= 1'b0;
      bands_ok_r  <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      iss_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bbt_pkg::REG_WINDOW_LENGTH:     wlen_r   <= cfg_data[bbt_pkg::WLEN_W-1:0];
          bbt_pkg::REG_BAND_WIDTH_FACTOR: factor_r <= cfg_data[FW-1:0];
          default: ;
        endcase
      end

      // output slot: drop on take, hold while stalled
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      v1_r <= issuing;
      v2_r <= v1_r && (state_r == ST_SQ);
      if (issuing) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            wslot_r <= (wslot_r == AW'(WINDOW_MAX - 1)) ? '0 : wslot_r + 1'b1;
            if (fill_r != LW'(WINDOW_MAX)) begin
              fill_r <= fill_r + 1'b1;
            end
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          iss_cnt_r <= '0;
          if (fill_r < len) begin
            bands_ok_r <= 1'b0;
            state_r    <= ST_DONE;
          end else begin
            bands_ok_r <= 1'b1;
            state_r    <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (pass_done) begin
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_sts.done) begin
            iss_cnt_r <= '0;
            state_r   <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (pass_done) begin
            state_r <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_sts.done) begin
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_sts.done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      newest_r <= wslot_r;
    end

    if (state_r == ST_CHECK || (state_r == ST_DIV1 && div_sts.done)) begin
      rd_ptr_r <= newest_r;
    end else if (issuing) begin
      rd_ptr_r <= (rd_ptr_r == '0) ? AW'(WINDOW_MAX - 1) : rd_ptr_r - 1'b1;
    end

    if (state_r == ST_CHECK) begin
      sum_r <= '0;
    end else if (state_r == ST_SUM && v1_r) begin
      sum_r <= sum_r + SW'(rd_data_r);
    end

    if (state_r == ST_DIV1 && div_sts.done) begin
      mean_r <= div_q[PW-1:0];
      acc_r  <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + DW'(sq_r);
    end

    if (v1_r) begin
      sq_r <= sq_nxt;
    end

    if (sqrt_sts.done) begin
      prod_r <= prod_nxt;
    end

    if (out_load) begin
      out_bv_r    <= bands_ok_r;
      out_mean_r  <= bands_ok_r ? mean_r    : '0;
      out_upper_r <= bands_ok_r ? upper_nxt : '0;
      out_lower_r <= bands_ok_r ? lower_nxt : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bands_valid = out_bv_r;
  assign out_mean_price  = out_mean_r;
  assign out_upper_band  = out_upper_r;
  assign out_lower_band  = out_lower_r;

  // A result outside a full window carries zeros only.
  `BBT_ASSERT_NOW(a_zero_when_unfilled, out_valid_r && !out_bv_r,
    out_mean_r == '0 && out_upper_r == '0 && out_lower_r == '0)

  // Bands bracket the mean.
  `BBT_ASSERT_NOW(a_bands_bracket_mean, out_valid_r && out_bv_r,
    out_lower_r <= out_mean_r && out_upper_r >= out_mean_r)

  // The shared divider is never restarted while busy.
  `BBT_ASSERT_NOW(a_div_free_at_start, div_start, !div_sts.busy)

  // Loading a result returns the sequencer to idle on the next cycle.
  `BBT_ASSERT_NEXT(a_load_then_idle, out_load, state_r == ST_IDLE && out_valid_r)

endmodule

[test/tb.sv]
// Self-checking testbench for the Bollinger band tracker.
`timescale 1ns / 1ps

module tb;
  import bbt_pkg::*;

  // Indexes past the register list; writes to them must leave the block untouched.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  localparam int RING_DEPTH = WINDOW_MAX_DEF;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  // Watchdog bound: the worst item plus idling on both sides, over about 900 items
  // and the long hold-off, stays well below this.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 870;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic                bands_valid;
    logic [PRICE_W-1:0]  mean_price;
    logic [PRICE_W-1:0]  upper_band;
    logic [PRICE_W-1:0]  lower_band;
  } band_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PRICE_W-1:0]    in_price;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_bands_valid;
  logic [PRICE_W-1:0]    out_mean_price;
  logic [PRICE_W-1:0]    out_upper_band;
  logic [PRICE_W-1:0]    out_lower_band;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the tracker: price history, write pointer, fill level, registers.
  logic [PRICE_W-1:0]  price_ring [RING_DEPTH];
  logic [SLOT_W-1:0]   next_slot;
  logic [WLEN_W-1:0]   fill_level;
  logic [WLEN_W-1:0]   window_reg;
  logic [FACTOR_W-1:0] factor_reg;

  band_t       pending_bands[$];
  int          errors;
  int unsigned cycle_count;
  bit          quiet_mode;
  int          sink_hold;
  logic [PRICE_W-1:0] drift_price;

  bollinger_band_tracker dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_price        (in_price),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bands_valid (out_bands_valid),
    .out_mean_price  (out_mean_price),
    .out_upper_band  (out_upper_band),
    .out_lower_band  (out_lower_band),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Integer square root, one result bit per trial from the top down.
  function automatic logic [ROOT_W-1:0] int_root(input logic [VAR_W-1:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] trial;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v)
        r = trial;
    end
    return r;
  endfunction

  // Store one price in the shadow ring and work out the bands it produces.
  function automatic band_t track_price(input logic [PRICE_W-1:0] p);
    band_t               r;
    int                  len;
    logic [SLOT_W-1:0]   pos;
    logic [63:0]         total;
    logic [127:0]        sq_sum;
    logic [127:0]        variance;
    logic [63:0]         dev;
    logic [PRICE_W-1:0]  sample;
    logic [PRICE_W-1:0]  mean_v;
    logic [ROOT_W-1:0]   sd;
    logic [47:0]         spread;
    logic [63:0]         up;
    r = '0;
    price_ring[next_slot] = p;
    next_slot = next_slot + 1'b1;
    if (fill_level < WLEN_W'(RING_DEPTH))
      fill_level = fill_level + 1'b1;

    // Clamp the length register: zero means one, anything past the ring means the ring.
    if (window_reg == '0)
      len = 1;
    else if (int'(window_reg) > RING_DEPTH)
      len = RING_DEPTH;
    else
      len = int'(window_reg);

    // Hold the outputs at zero until the window has filled.
    if (int'(fill_level) < len)
      return r;

    total = '0;
    for (int k = 0; k < len; k++) begin
      pos = next_slot - 1'b1 - SLOT_W'(k);
      total += 64'(price_ring[pos]);
    end
    mean_v = PRICE_W'(total / 64'(len));

    // Squared deviations can pass 64 bits over a full window; keep them wide.
    sq_sum = '0;
    for (int k = 0; k < len; k++) begin
      pos = next_slot - 1'b1 - SLOT_W'(k);
      sample = price_ring[pos];
      dev = (sample >= mean_v) ? 64'(sample - mean_v) : 64'(mean_v - sample);
      sq_sum += dev * dev;
    end
    variance = sq_sum / 128'(len);
    sd = int_root(variance[VAR_W-1:0]);

    // Q8.8 factor times Q16.16 deviation, truncated back to Q16.16.
    spread = 48'((64'(factor_reg) * 64'(sd)) >> FRAC_SHIFT);
    up = 64'(mean_v) + 64'(spread);
    r.bands_valid = 1'b1;
    r.mean_price  = mean_v;
    r.upper_band  = (up > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : up[31:0];
    r.lower_band  = (64'(spread) >= 64'(mean_v)) ? '0 : mean_v - spread[31:0];
    return r;
  endfunction

  // Idle cycles before the next item on either side; none at all in quiet stretches.
  function automatic int draw_wait();
    if (quiet_mode || $urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, 16);
  endfunction

  // Mostly a drifting, market-like series; now and then full-range noise or a rail.
  function automatic logic [PRICE_W-1:0] next_price();
    logic [PRICE_W-1:0] jitter;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: begin
        jitter = $urandom_range(0, 32'h0004_0000);
        drift_price = drift_price + jitter - 32'h0002_0000;
        return drift_price;
      end
    endcase
  endfunction

  // Offer one price, hold it through any stall, and log its bands on acceptance.
  task automatic send_price(input logic [PRICE_W-1:0] p);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_price <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_bands.push_back(track_price(p));
  endtask

  // Drop valid and hold off until every logged result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WINDOW_LENGTH:     window_reg = data[WLEN_W-1:0];
      REG_BAND_WIDTH_FACTOR: factor_reg = data;
      default: ;  // unused indexes change nothing
    endcase
  endtask

  // Write both registers back to back, optionally poke the unused indexes, then release.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] wlen_data,
                              input logic [CFG_DATA_W-1:0] factor_data,
                              input bit with_unused);
    write_reg(REG_WINDOW_LENGTH, wlen_data);
    write_reg(REG_BAND_WIDTH_FACTOR, factor_data);
    if (with_unused) begin
      write_reg(REG_UNUSED_A, CFG_DATA_W'($urandom()));
      write_reg(REG_UNUSED_B, CFG_DATA_W'($urandom()));
    end
    cfg_valid <= 1'b0;
  endtask

  // Reset values of the registers: a 20-price window at factor 2.0. Alternate the
  // rails so the last item sees a huge deviation, saturating both bands.
  task automatic test_reset_defaults();
    for (int i = 0; i < 20; i++)
      send_price((i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
  endtask

  // Length of zero, length past the ring, tiny windows at the largest factor,
  // and a length change with the history kept.
  task automatic test_length_extremes();
    wait_for_results();
    program_regs(16'hFF80, 16'hFFFF, 1'b1);  // length field reads zero: one price
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
    wait_for_results();
    program_regs(16'h0002, 16'hFFFF, 1'b0);
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0001_0000);
    wait_for_results();
    program_regs(16'h007F, 16'h0000, 1'b0);  // past the ring: clamp to the full ring
    send_price(32'h8000_0000);
    send_price(32'h7FFF_FFFF);
    wait_for_results();
    program_regs(16'h0003, 16'h0100, 1'b0);
    send_price(32'h1234_5678);
  endtask

  // Freeze the result side for a long stretch while prices keep coming, so the
  // block fills up and must stall its input.
  task automatic test_backpressure();
    wait_for_results();
    quiet_mode = 1'b1;
    sink_hold = 1200;
    for (int i = 0; i < 8; i++)
      send_price(next_price());
    wait_for_results();
    quiet_mode = 1'b0;
  endtask

  // Phases of random prices, each under fresh register values, with the odd
  // full pause on the sending side.
  task automatic test_random_traffic();
    int                  sent;
    int                  phase_len;
    logic [WLEN_W-1:0]   wl;
    logic [CFG_DATA_W-1:0] wlen_data;
    logic [CFG_DATA_W-1:0] factor_data;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       wl = '0;
        1:       wl = WLEN_W'(RING_DEPTH);
        2:       wl = WLEN_W'($urandom_range(RING_DEPTH + 1, 127));
        3, 4:    wl = WLEN_W'($urandom_range(17, RING_DEPTH - 1));
        default: wl = WLEN_W'($urandom_range(1, 16));
      endcase
      // Junk in the upper data bits must be ignored.
      wlen_data = CFG_DATA_W'($urandom());
      wlen_data[WLEN_W-1:0] = wl;
      case ($urandom_range(0, 5))
        0:       factor_data = 16'h0000;
        1:       factor_data = 16'hFFFF;
        2:       factor_data = FACTOR_RESET;
        default: factor_data = CFG_DATA_W'($urandom());
      endcase
      wait_for_results();
      program_regs(wlen_data, factor_data, $urandom_range(0, 3) == 0);
      quiet_mode = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        send_price(next_price());
        sent++;
        if ($urandom_range(0, 39) == 0)
          wait_for_results();
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_price    <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_WINDOW_LENGTH;
    cfg_data    <= '0;
    errors      = 0;
    quiet_mode  = 1'b0;
    sink_hold   = 0;
    drift_price = 32'h0064_0000;
    next_slot   = '0;
    fill_level  = '0;
    window_reg  = WLEN_RESET;
    factor_reg  = FACTOR_RESET;
    for (int i = 0; i < RING_DEPTH; i++)
      price_ring[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_length_extremes();
    test_backpressure();
    test_random_traffic();

    // Let the last results drain, then give the block time to show any stray one.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_bands.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Result side: stall a random number of cycles before each result, or take a
  // requested long hold-off, then release until one result is taken.
  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        n = sink_hold;
        sink_hold = 0;
      end else begin
        n = draw_wait();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each taken result against the oldest logged expectation.
  always @(posedge clk) begin
    band_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bands.size() == 0) begin
        $error("unexpected result: bands_valid=%0b mean_price=%h", out_bands_valid,
               out_mean_price);
        errors++;
      end else begin
        want = pending_bands.pop_front();
        if (out_bands_valid !== want.bands_valid) begin
          $error("bands_valid: expected %0b, got %0b", want.bands_valid, out_bands_valid);
          errors++;
        end
        if (out_mean_price !== want.mean_price) begin
          $error("mean_price: expected %h, got %h", want.mean_price, out_mean_price);
          errors++;
        end
        if (out_upper_band !== want.upper_band) begin
          $error("upper_band: expected %h, got %h", want.upper_band, out_upper_band);
          errors++;
        end
        if (out_lower_band !== want.lower_band) begin
          $error("lower_band: expected %h, got %h", want.lower_band, out_lower_band);
          errors++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
